@@ rtl/odhh_pkg.sv @@
// odhh_pkg: shared types, constants and the cosine table builder for the
// heading-hold drive mixer. No dependencies.
`default_nettype none

package odhh_pkg;

    // quarter-wave resolution of the cosine table
    localparam int QUARTER_WAVE_ENTRIES = 900;
    // tenth-degree steps in a quarter turn
    localparam int ANGLE_QUARTER = 900;
    localparam int COS_AW        = $clog2(ANGLE_QUARTER + 1);

    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam int     SQRT2_Q16   = 92682;
    localparam int     DRIVE_MAX   = 32767;

    // taylor series divisors (2n-1)*(2n) for n = 1..12
    localparam longint TAYLOR_DEN [12] = '{
        64'sd2, 64'sd12, 64'sd30, 64'sd56, 64'sd90, 64'sd132,
        64'sd182, 64'sd240, 64'sd306, 64'sd380, 64'sd462, 64'sd552
    };

    // gain schedule, q0.16
    localparam int ERR_HI  = 1000;
    localparam int ERR_MID = 400;
    localparam int KP_HI   = 16384;
    localparam int KI_HI   = 655;
    localparam int KD_HI   = 4588;
    localparam int KP_MID  = 9830;
    localparam int KI_MID  = 3932;
    localparam int KD_MID  = 2621;
    localparam int KP_LO   = 6554;
    localparam int KI_LO   = 1966;
    localparam int KD_LO   = 655;

    // register indexes
    localparam logic [2:0] REG_WHEEL0 = 3'd0;
    localparam logic [2:0] REG_WHEEL1 = 3'd1;
    localparam logic [2:0] REG_WHEEL2 = 3'd2;
    localparam logic [2:0] REG_WHEEL3 = 3'd3;
    localparam logic [2:0] REG_ROT    = 3'd4;

    typedef logic [ANGLE_QUARTER:0][14:0] t_cos_tab;

    typedef enum logic [4:0] {
        S_IDLE,
        S_PREP,
        S_COS_A,
        S_COS_D,
        S_M0,
        S_M1,
        S_M2,
        S_M3,
        S_CORR,
        S_P0,
        S_P1,
        S_P2,
        S_P3,
        S_P4,
        S_P5,
        S_P6,
        S_P7,
        S_P8,
        S_P9,
        S_P10,
        S_DIV_INIT,
        S_DIV_RUN,
        S_DIV_DONE,
        S_DONE
    } t_state;

    // magnitude modulo 3600 by restoring steps, magnitude below 3600*32
    function automatic logic [11:0] mod3600(input logic [16:0] mag);
        logic [16:0] m;
        m = mag;
        for (int k = 4; k >= 0; k--) begin
            if (m >= (17'd3600 << k)) begin
                m = m - (17'd3600 << k);
            end
        end
        return m[11:0];
    endfunction

    // one q1.14 quarter-wave entry by a q2.30 taylor series
    function automatic logic [14:0] cos_entry(input int k);
        longint x;
        longint x2;
        longint term;
        longint sum;
        x    = HALF_PI_Q30 * longint'(k) / QUARTER_WAVE_ENTRIES;
        x2   = (x * x) >>> 30;
        term = longint'(1) <<< 30;
        sum  = term;
        for (int n = 1; n <= 12; n++) begin
            term = ((term * x2) >>> 30) / TAYLOR_DEN[n - 1];
            if ((n % 2) == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        sum = (sum + 32768) >>> 16;
        if (sum > 16384) begin
            sum = 16384;
        end
        return 15'(sum);
    endfunction

    // table indexed by the remainder within a quarter turn
    function automatic t_cos_tab build_cos_tab();
        t_cos_tab tab;
        for (int r = 0; r <= ANGLE_QUARTER; r++) begin
            tab[r] = cos_entry(r * QUARTER_WAVE_ENTRIES / ANGLE_QUARTER);
        end
        return tab;
    endfunction

endpackage

`default_nettype wire

@@ rtl/omni_drive_heading_hold_core.sv @@
// omni_drive_heading_hold_core: heading-hold drive mixer for a four-wheel
// omni base, one shared multiplier and a restoring divider under a sequencer.
// Depends on odhh_pkg.
//
//  channel   direction  width  contents
//  s_*       in         128    heading, target_heading, travel_angle,
//                              target_speed, ramp_period, now_ms
//  m_*       out        88     drive0..drive3, ramped_speed_out, div_fault
//  apb       in/out     32     wheel0..3 angle, rot_limit at 4*index
//
// one item goes from its accepting edge to a valid result through: latch,
// the six cosine lookups (registered rom read), the gain products and clamp,
// each wheel pair on the shared 34x34 multiplier, each drive in the
// one-bit-a-cycle divider (none for a pair with a zero or negative
// denominator) and the load of the output register
// s_tready is high only while the sequencer is idle
// a finished item sits in the output register; the sequencer holds in its
// last state while that register is full and not being taken
// synchronous active-low reset covers control, config, ramp and error state
`default_nettype none

module omni_drive_heading_hold_core
    import odhh_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // heading[15:0], target_heading[31:16], travel_angle[47:32],
    // target_speed[63:48], ramp_period[95:64], now_ms[127:96]
    input  wire logic [127:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // drive0[15:0], drive1[31:16], drive2[47:32], drive3[63:48],
    // ramped_speed_out[79:64], div_fault[80], zero fill[87:81]
    output logic [87:0]       m_tdata,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [4:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam t_cos_tab COS_TAB = build_cos_tab();

    t_state r_state, n_state;

    // configuration
    logic signed [11:0] r_w0, r_w1, r_w2, r_w3;
    logic [14:0]        r_rot;

    // latched item
    logic signed [15:0] r_heading, r_target, r_travel, r_tspeed;
    logic [31:0]        r_period, r_now;

    // persistent state
    logic signed [15:0] r_speed;
    logic [31:0]        r_last_time;
    logic signed [15:0] r_prev_err;

    // working registers
    logic signed [15:0] r_err, r_corr;
    logic signed [15:0] r_cosv [0:5];
    logic [2:0]         r_ci;
    logic [14:0]        r_rom;
    logic               r_rom_neg;
    logic signed [67:0] r_prod;
    logic signed [63:0] r_acc;
    logic signed [33:0] r_apaq;
    logic signed [31:0] r_apt, r_aqt;
    logic signed [46:0] r_g;
    logic signed [33:0] r_sk;
    logic signed [63:0] r_xp, r_xq;
    logic [63:0]        r_rem;
    logic [17:0]        r_q;
    logic [4:0]         r_cnt;
    logic               r_xneg;
    logic               r_pair, r_half;
    logic signed [15:0] r_d [0:3];
    logic               r_fault;
    logic [87:0]        r_m_tdata;
    logic               r_m_tvalid;

    // multiplier operands
    logic signed [33:0] w_ma, w_mb;

    // ---------------- combinational datapath ----------------

    // heading wrap and error
    logic [16:0]        w_hmag;
    logic [11:0]        w_hmod;
    logic signed [13:0] w_hr, w_hwrap;
    logic signed [15:0] w_err;
    always_comb begin
        w_hmag = r_heading[15] ? 17'(-18'(r_heading)) : 17'(r_heading);
        w_hmod = mod3600(w_hmag);
        w_hr   = r_heading[15] ? -14'($signed({2'b0, w_hmod})) : 14'($signed({2'b0, w_hmod}));
        if (w_hr >= 14'sd1800) begin
            w_hwrap = w_hr - 14'sd3600;
        end else if (w_hr < -14'sd1800) begin
            w_hwrap = w_hr + 14'sd3600;
        end else begin
            w_hwrap = w_hr;
        end
        w_err = r_target - 16'(w_hwrap);
    end

    // ramp step
    logic [31:0] w_elapsed;
    assign w_elapsed = r_now - r_last_time;

    // cosine angle selection and quadrant fold
    logic signed [17:0]  w_ang;
    logic [16:0]         w_amag;
    logic [11:0]         w_amod, w_red;
    logic [COS_AW-1:0]   w_addr;
    logic                w_cneg;
    always_comb begin
        case (r_ci)
            3'd0:    w_ang = 18'(r_w0) - 18'(r_travel) + 18'(r_heading);
            3'd1:    w_ang = 18'(r_w1) - 18'(r_travel) + 18'(r_heading);
            3'd2:    w_ang = 18'(r_w2) - 18'(r_travel) + 18'(r_heading);
            3'd3:    w_ang = 18'(r_w3) - 18'(r_travel) + 18'(r_heading);
            3'd4:    w_ang = 18'(r_w0) - 18'(r_w3);
            default: w_ang = 18'(r_w1) - 18'(r_w2);
        endcase
        w_amag = w_ang[17] ? 17'(-w_ang) : 17'(w_ang);
        w_amod = mod3600(w_amag);
        w_red  = (w_ang[17] && (w_amod != 12'd0)) ? 12'd3600 - w_amod : w_amod;
        if (w_red < 12'd900) begin
            w_addr = COS_AW'(w_red);
            w_cneg = 1'b0;
        end else if (w_red < 12'd1800) begin
            w_addr = COS_AW'(12'd1800 - w_red);
            w_cneg = 1'b1;
        end else if (w_red < 12'd2700) begin
            w_addr = COS_AW'(w_red - 12'd1800);
            w_cneg = 1'b1;
        end else begin
            w_addr = COS_AW'(12'd3600 - w_red);
            w_cneg = 1'b0;
        end
    end

    // gain schedule
    logic signed [16:0] w_err17;
    logic [16:0]        w_abs;
    logic [15:0]        w_kp, w_ki, w_kd;
    always_comb begin
        w_err17 = 17'(r_err);
        w_abs   = w_err17[16] ? unsigned'(-w_err17) : unsigned'(w_err17);
        if (w_abs >= 17'(ERR_HI)) begin
            w_kp = 16'(KP_HI);
            w_ki = 16'(KI_HI);
            w_kd = 16'(KD_HI);
        end else if (w_abs >= 17'(ERR_MID)) begin
            w_kp = 16'(KP_MID);
            w_ki = 16'(KI_MID);
            w_kd = 16'(KD_MID);
        end else begin
            w_kp = 16'(KP_LO);
            w_ki = 16'(KI_LO);
            w_kd = 16'(KD_LO);
        end
    end

    // correction: truncate toward zero, clamp
    logic signed [17:0] w_corr_t, w_rot, w_corr_c;
    always_comb begin
        w_corr_t = $signed(r_acc[33:16])
                 + 18'((r_acc[63] && (r_acc[15:0] != 16'd0)) ? 1 : 0);
        w_rot    = $signed({3'b0, r_rot});
        if (w_corr_t >= w_rot) begin
            w_corr_c = w_rot;
        end else if (w_corr_t < -w_rot) begin
            w_corr_c = -w_rot;
        end else begin
            w_corr_c = w_corr_t;
        end
    end

    // pair operands
    logic signed [15:0] w_ap, w_aq, w_t;
    logic signed [31:0] w_np, w_nq;
    always_comb begin
        w_ap = r_pair ? r_cosv[1] : r_cosv[0];
        w_aq = r_pair ? r_cosv[2] : r_cosv[3];
        w_t  = r_pair ? r_cosv[5] : r_cosv[4];
        w_np = (32'(w_ap) <<< 14) - r_aqt;
        w_nq = (32'(w_aq) <<< 14) - r_apt;
    end

    // divider
    logic [47:0]        w_den;
    logic signed [63:0] w_x;
    logic [63:0]        w_xmag;
    logic [64:0]        w_dsh;
    logic [64:0]        w_dsat;
    assign w_den  = {r_g[45:0], 2'b00};
    assign w_x    = r_half ? r_xq : r_xp;
    assign w_xmag = w_x[63] ? unsigned'(-w_x) : unsigned'(w_x);
    assign w_dsh  = 65'(w_den) << r_cnt;
    assign w_dsat = 65'(w_den) << 17;

    // drive from quotient, remainder sign and correction
    logic signed [19:0] w_qx, w_s, w_sa;
    logic signed [15:0] w_drive;
    logic [1:0]         w_didx;
    always_comb begin
        w_qx = r_xneg ? -$signed({2'b0, r_q}) : $signed({2'b0, r_q});
        w_s  = 20'(r_corr) + w_qx;
        w_sa = w_s;
        if (r_rem != 64'd0) begin
            if ((w_s > 20'sd0) && r_xneg) begin
                w_sa = w_s - 20'sd1;
            end else if ((w_s < 20'sd0) && !r_xneg) begin
                w_sa = w_s + 20'sd1;
            end
        end
        if (w_sa > 20'(DRIVE_MAX)) begin
            w_drive = 16'(DRIVE_MAX);
        end else if (w_sa < -20'(DRIVE_MAX)) begin
            w_drive = -16'(DRIVE_MAX);
        end else begin
            w_drive = 16'(w_sa);
        end
        // right pair feeds wheels 0 and 3, left pair wheels 1 and 2
        w_didx = {r_half, r_pair ^ r_half};
    end

    logic w_out_free;
    assign w_out_free = !r_m_tvalid || m_tready;

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:     if (s_tvalid) n_state = S_PREP;
            S_PREP:     n_state = S_COS_A;
            S_COS_A:    n_state = S_COS_D;
            S_COS_D:    n_state = (r_ci == 3'd5) ? S_M0 : S_COS_A;
            S_M0:       n_state = S_M1;
            S_M1:       n_state = S_M2;
            S_M2:       n_state = S_M3;
            S_M3:       n_state = S_CORR;
            S_CORR:     n_state = S_P0;
            S_P0:       n_state = S_P1;
            S_P1:       n_state = S_P2;
            S_P2:       n_state = S_P3;
            S_P3:       n_state = S_P4;
            S_P4:       n_state = S_P5;
            S_P5:       n_state = S_P6;
            S_P6:       n_state = S_P7;
            S_P7:       n_state = S_P8;
            S_P8:       n_state = S_P9;
            S_P9:       n_state = S_P10;
            S_P10: begin
                if (r_g <= 47'sd0) begin
                    n_state = r_pair ? S_DONE : S_P0;
                end else begin
                    n_state = S_DIV_INIT;
                end
            end
            S_DIV_INIT: n_state = (65'(w_xmag) >= w_dsat) ? S_DIV_DONE : S_DIV_RUN;
            S_DIV_RUN:  if (r_cnt == 5'd0) n_state = S_DIV_DONE;
            S_DIV_DONE: begin
                if (!r_half) begin
                    n_state = S_DIV_INIT;
                end else begin
                    n_state = r_pair ? S_DONE : S_P0;
                end
            end
            S_DONE:     if (w_out_free) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // ---------------- sequencer outputs ----------------
    always_comb begin
        s_tready = 1'b0;
        w_ma     = 34'sd0;
        w_mb     = 34'sd0;
        case (r_state)
            S_IDLE: s_tready = 1'b1;
            S_M0: begin
                w_ma = 34'($signed({1'b0, w_kp}));
                w_mb = 34'(r_err);
            end
            S_M1: begin
                w_ma = 34'($signed({1'b0, w_ki}));
                w_mb = 34'(17'(r_err) + 17'(r_prev_err));
            end
            S_M2: begin
                w_ma = 34'($signed({1'b0, w_kd}));
                w_mb = 34'(17'(r_err) - 17'(r_prev_err));
            end
            S_P0: begin
                w_ma = 34'(w_ap);
                w_mb = 34'(w_ap);
            end
            S_P1: begin
                w_ma = 34'(w_aq);
                w_mb = 34'(w_aq);
            end
            S_P2: begin
                w_ma = 34'(w_ap);
                w_mb = 34'(w_aq);
            end
            S_P3: begin
                w_ma = 34'(w_ap);
                w_mb = 34'(w_t);
            end
            S_P4: begin
                w_ma = r_apaq;
                w_mb = 34'(w_t);
            end
            S_P5: begin
                w_ma = 34'(w_aq);
                w_mb = 34'(w_t);
            end
            S_P6: begin
                w_ma = 34'(r_speed);
                w_mb = 34'(SQRT2_Q16);
            end
            S_P8: begin
                w_ma = r_sk;
                w_mb = 34'(w_np);
            end
            S_P9: begin
                w_ma = r_sk;
                w_mb = 34'(w_nq);
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == S_DONE) && w_out_free) begin
                r_m_tvalid <= 1'b1;
            end else if (m_tready) begin
                r_m_tvalid <= 1'b0;
            end
        end
    end

    // configuration and persistent state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w0        <= 12'sd450;
            r_w1        <= 12'sd1350;
            r_w2        <= -12'sd1350;
            r_w3        <= -12'sd450;
            r_rot       <= 15'd50;
            r_speed     <= 16'sd0;
            r_last_time <= 32'd0;
            r_prev_err  <= 16'sd0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:2])
                    REG_WHEEL0: r_w0  <= pwdata[11:0];
                    REG_WHEEL1: r_w1  <= pwdata[11:0];
                    REG_WHEEL2: r_w2  <= pwdata[11:0];
                    REG_WHEEL3: r_w3  <= pwdata[11:0];
                    REG_ROT:    r_rot <= pwdata[14:0];
                    default:    r_rot <= r_rot;
                endcase
            end
            if (r_state == S_PREP) begin
                if (w_elapsed >= r_period) begin
                    if (r_speed < r_tspeed) begin
                        r_speed <= r_speed + 16'sd1;
                    end else if (r_speed > r_tspeed) begin
                        r_speed <= r_speed - 16'sd1;
                    end
                    r_last_time <= r_now;
                end
            end
            if (r_state == S_CORR) begin
                r_prev_err <= r_err;
            end
        end
    end

    // cosine rom, registered read
    always_ff @(posedge i_clk) begin
        r_rom     <= COS_TAB[w_addr];
        r_rom_neg <= w_cneg;
    end

    // shared multiplier
    always_ff @(posedge i_clk) begin
        r_prod <= w_ma * w_mb;
    end

    // working datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_heading <= s_tdata[15:0];
                r_target  <= s_tdata[31:16];
                r_travel  <= s_tdata[47:32];
                r_tspeed  <= s_tdata[63:48];
                r_period  <= s_tdata[95:64];
                r_now     <= s_tdata[127:96];
            end
            S_PREP: begin
                r_err   <= w_err;
                r_ci    <= 3'd0;
                r_fault <= 1'b0;
                r_pair  <= 1'b0;
            end
            S_COS_D: begin
                r_cosv[r_ci] <= r_rom_neg ? -$signed({1'b0, r_rom}) : $signed({1'b0, r_rom});
                r_ci         <= r_ci + 3'd1;
            end
            S_M1:   r_acc <= 64'(r_prod);
            S_M2:   r_acc <= r_acc + 64'(r_prod);
            S_M3:   r_acc <= r_acc + 64'(r_prod);
            S_CORR: r_corr <= 16'(w_corr_c);
            S_P1:   r_acc <= 64'(r_prod);
            S_P2:   r_acc <= r_acc + 64'(r_prod);
            S_P3:   r_apaq <= 34'(r_prod);
            S_P4:   r_apt <= 32'(r_prod);
            S_P5:   r_g <= (47'(r_acc) <<< 14) - (47'(r_prod) <<< 1);
            S_P6:   r_aqt <= 32'(r_prod);
            S_P7:   r_sk <= 34'(r_prod);
            S_P9:   r_xp <= r_pair ? -64'(r_prod) : 64'(r_prod);
            S_P10: begin
                r_xq   <= r_pair ? -64'(r_prod) : 64'(r_prod);
                r_half <= 1'b0;
                if (r_g <= 47'sd0) begin
                    r_fault <= 1'b1;
                    if (r_pair) begin
                        r_d[1] <= 16'sd0;
                        r_d[2] <= 16'sd0;
                    end else begin
                        r_d[0] <= 16'sd0;
                        r_d[3] <= 16'sd0;
                        r_pair <= 1'b1;
                    end
                end
            end
            S_DIV_INIT: begin
                r_rem  <= w_xmag;
                r_xneg <= w_x[63];
                r_cnt  <= 5'd16;
                r_q    <= (65'(w_xmag) >= w_dsat) ? 18'h20000 : 18'd0;
            end
            S_DIV_RUN: begin
                if (65'(r_rem) >= w_dsh) begin
                    r_rem       <= 64'(65'(r_rem) - w_dsh);
                    r_q[r_cnt]  <= 1'b1;
                end
                r_cnt <= r_cnt - 5'd1;
            end
            S_DIV_DONE: begin
                r_d[w_didx] <= w_drive;
                if (!r_half) begin
                    r_half <= 1'b1;
                end else if (!r_pair) begin
                    r_pair <= 1'b1;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    r_m_tdata <= {7'd0, r_fault, r_speed, r_d[3], r_d[2], r_d[1], r_d[0]};
                end
            end
            default: begin
                r_ci <= r_ci;
            end
        endcase
    end

    // ---------------- ports ----------------
    assign m_tvalid = r_m_tvalid;
    assign m_tdata  = r_m_tdata;
    assign pready   = 1'b1;

    always_comb begin
        case (paddr[4:2])
            REG_WHEEL0: prdata = 32'(r_w0);
            REG_WHEEL1: prdata = 32'(r_w1);
            REG_WHEEL2: prdata = 32'(r_w2);
            REG_WHEEL3: prdata = 32'(r_w3);
            REG_ROT:    prdata = {17'd0, r_rot};
            default:    prdata = 32'd0;
        endcase
    end

    // ---------------- assertions ----------------

    // an accepted item starts the sequencer
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_tvalid && s_tready) |=> (r_state == S_PREP))
        else $error("accepted item did not start the sequencer");

    // the divider never shifts past its top quotient bit
    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV_RUN) |-> (r_cnt <= 5'd16))
        else $error("divider step count out of range");

    // a finished item with a free output register is shown next cycle
    a_done_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DONE) && w_out_free) |=> (m_tvalid && (r_state == S_IDLE)))
        else $error("finished item not presented");

    // saturated drives never reach the most negative code
    a_drive_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> ((m_tdata[15:0] != 16'h8000) && (m_tdata[31:16] != 16'h8000)
                   && (m_tdata[47:32] != 16'h8000) && (m_tdata[63:48] != 16'h8000)))
        else $error("drive outside saturation range");

endmodule

`default_nettype wire

@@ tb/sv/tb_omni_drive_heading_hold_checker.sv @@
// checker for the heading-hold drive mixer: watches the apb port and both item
// channels, predicts every result and compares it. depends on odhh_pkg
`timescale 1ns / 1ps

module tb_omni_drive_heading_hold_checker
    import odhh_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_tvalid,
    input  wire logic         s_tready,
    input  wire logic [127:0] s_tdata,
    input  wire logic         m_tvalid,
    input  wire logic         m_tready,
    input  wire logic [87:0]  m_tdata,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [4:0]   paddr,
    input  wire logic [31:0]  pwdata,
    input  wire logic         pready,
    output int                o_fail_count,
    output int                o_pending
);

    typedef struct {
        logic [3:0][15:0] drive;
        logic [15:0]      speed;
        logic             fault;
    } t_drive_set;

    t_drive_set  drive_q[$];
    int          cos_rom[0:QUARTER_WAVE_ENTRIES];
    int          mount[4];
    int          corr_limit;
    int          cur_speed;
    logic [31:0] last_step;
    int          last_err;

    function automatic int taylor_cos(int k);
        longint x, x2, term, sum;
        x    = HALF_PI_Q30 * longint'(k) / longint'(QUARTER_WAVE_ENTRIES);
        x2   = (x * x) >>> 30;
        term = longint'(1) <<< 30;
        sum  = term;
        for (int n = 1; n <= 12; n++) begin
            term = ((term * x2) >>> 30) / longint'((2 * n - 1) * (2 * n));
            sum  = (n % 2 == 1) ? sum - term : sum + term;
        end
        if (sum < 0) sum = 0;
        sum = (sum + 32768) >>> 16;
        if (sum > 16384) sum = 16384;
        return int'(sum);
    endfunction

    initial begin
        for (int k = 0; k <= QUARTER_WAVE_ENTRIES; k++) begin
            cos_rom[k] = taylor_cos(k);
        end
    end

    function automatic int quad_cos(int r);
        return cos_rom[(r * QUARTER_WAVE_ENTRIES) / 900];
    endfunction

    function automatic int angle_cos(int a);
        int q, r;
        a = a % 3600;
        if (a < 0) a += 3600;
        q = a / 900;
        r = a % 900;
        case (q)
            0: return quad_cos(r);
            1: return -quad_cos(900 - r);
            2: return -quad_cos(r);
            default: return quad_cos(900 - r);
        endcase
    endfunction

    function automatic longint clip_drive(longint v);
        if (v > DRIVE_MAX) return DRIVE_MAX;
        if (v < -DRIVE_MAX) return -DRIVE_MAX;
        return v;
    endfunction

    // coupled pair, returns 1 on a zero or negative denominator
    function automatic bit pair_mix(longint corr, longint spd, longint ap, longint aq,
                                    longint t, longint sgn,
                                    output longint dp, output longint dq);
        longint g, np, nq, den, sk;
        g = (ap * ap + aq * aq) * 16384 - 2 * ap * aq * t;
        if (g <= 0) begin
            dp = 0;
            dq = 0;
            return 1;
        end
        np  = ap * 16384 - aq * t;
        nq  = aq * 16384 - ap * t;
        den = 4 * g;
        sk  = spd * SQRT2_Q16;
        dp  = clip_drive((corr * den + sgn * sk * np) / den);
        dq  = clip_drive((corr * den + sgn * sk * nq) / den);
        return 0;
    endfunction

    task automatic predict_tick(input logic [127:0] d);
        int          hdg, tgt, trav, tspd, wrapped, err, abs_err, corr, t0, t1;
        logic [15:0] err16;
        logic [31:0] period, now;
        longint      kp, ki, kd, acc;
        int          proj[4];
        longint      dr[4];
        bit          fault;
        t_drive_set  e;
        hdg    = int'($signed(d[15:0]));
        tgt    = int'($signed(d[31:16]));
        trav   = int'($signed(d[47:32]));
        tspd   = int'($signed(d[63:48]));
        period = d[95:64];
        now    = d[127:96];
        // speed ramp, elapsed time wraps mod 2^32
        if (32'(now - last_step) >= period) begin
            if (cur_speed < tspd) cur_speed++;
            else if (cur_speed > tspd) cur_speed--;
            last_step = now;
        end
        wrapped = hdg % 3600;
        if (wrapped >= 1800) wrapped -= 3600;
        else if (wrapped < -1800) wrapped += 3600;
        err16   = 16'(tgt - wrapped);
        err     = int'($signed(err16));
        abs_err = err < 0 ? -err : err;
        if (abs_err >= ERR_HI) begin
            kp = KP_HI; ki = KI_HI; kd = KD_HI;
        end else if (abs_err >= ERR_MID) begin
            kp = KP_MID; ki = KI_MID; kd = KD_MID;
        end else begin
            kp = KP_LO; ki = KI_LO; kd = KD_LO;
        end
        acc  = kp * err + ki * (longint'(err) + last_err) + kd * (longint'(err) - last_err);
        corr = int'(acc / 65536);
        if (corr >= corr_limit) corr = corr_limit;
        else if (corr < -corr_limit) corr = -corr_limit;
        last_err = err;
        for (int i = 0; i < 4; i++) proj[i] = angle_cos(mount[i] - trav + hdg);
        t0    = angle_cos(mount[0] - mount[3]);
        t1    = angle_cos(mount[1] - mount[2]);
        fault = pair_mix(corr, cur_speed, proj[0], proj[3], t0, 1, dr[0], dr[3]);
        if (pair_mix(corr, cur_speed, proj[1], proj[2], t1, -1, dr[1], dr[2])) fault = 1;
        for (int i = 0; i < 4; i++) e.drive[i] = 16'(dr[i]);
        e.speed = 16'(cur_speed);
        e.fault = fault;
        drive_q.push_back(e);
    endtask

    task automatic report_mismatch(input string field, input int want, input int got);
        $display("mismatch %s: expected %0d got %0d at %0t", field, want, got, $realtime);
        o_fail_count++;
    endtask

    initial o_fail_count = 0;
    initial o_pending = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            mount      = '{450, 1350, -1350, -450};
            corr_limit = 50;
            cur_speed  = 0;
            last_step  = '0;
            last_err   = 0;
            drive_q.delete();
        end else begin
            // register writes, indexes past the list fall through
            if (psel && penable && pwrite && pready) begin
                if (paddr[4:2] <= REG_WHEEL3) mount[paddr[4:2]] = int'($signed(pwdata[11:0]));
                else if (paddr[4:2] == REG_ROT) corr_limit = int'(pwdata[14:0]);
            end
            if (m_tvalid && m_tready) begin
                if (drive_q.size() == 0) begin
                    report_mismatch("unexpected item", 0, 1);
                end else begin
                    t_drive_set e;
                    e = drive_q.pop_front();
                    for (int i = 0; i < 4; i++) begin
                        if (m_tdata[16*i +: 16] !== e.drive[i]) begin
                            report_mismatch($sformatf("drive%0d", i), $signed(e.drive[i]),
                                            $signed(m_tdata[16*i +: 16]));
                        end
                    end
                    if (m_tdata[79:64] !== e.speed)
                        report_mismatch("ramped_speed", $signed(e.speed), $signed(m_tdata[79:64]));
                    if (m_tdata[80] !== e.fault)
                        report_mismatch("div_fault", e.fault, m_tdata[80]);
                end
            end
            if (s_tvalid && s_tready) predict_tick(s_tdata);
        end
        o_pending = drive_q.size();
    end

endmodule

@@ tb/sv/tb_omni_drive_heading_hold_core.sv @@
// top of the heading-hold drive mixer bench: clock, reset, apb setup, item
// stimulus with random gaps and the verdict. depends on odhh_pkg, the core and
// tb_omni_drive_heading_hold_checker
`timescale 1ns / 1ps

module tb_omni_drive_heading_hold_core;
    import odhh_pkg::*;

    localparam int         RUN_LIMIT = 1000000;
    localparam int         HOLD_LEN  = 1500;
    // index past the register list, must be ignored
    localparam logic [2:0] REG_SPARE = 3'd7;

    logic         i_clk = 0;
    logic         i_rst_n = 0;
    logic         s_tvalid = 0;
    logic [127:0] s_tdata = '0;
    logic         m_tready = 0;
    logic         psel = 0;
    logic         penable = 0;
    logic         pwrite = 0;
    logic [4:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    wire          s_tready;
    wire          m_tvalid;
    wire  [87:0]  m_tdata;
    wire  [31:0]  prdata;
    wire          pready;
    int           fail_count;
    int           pending;

    int           cycles = 0;
    int           sent = 0;
    bit           hold = 0;      // long receiver hold-off
    bit           calm = 0;      // no idling on either side
    logic [31:0]  clock_ms = 0;  // running millisecond stamp

    omni_drive_heading_hold_core u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    tb_omni_drive_heading_hold_checker u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        #10 i_clk = 1;
        #10 i_clk = 0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > RUN_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    // receiver side: random stalls plus the long hold-off
    initial begin
        int wait_left;
        wait_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold) begin
                m_tready = 0;
            end else if (wait_left > 0) begin
                m_tready = 0;
                wait_left--;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                m_tready  = 0;
                wait_left = pick_gap();
            end else begin
                m_tready = 1;
            end
        end
    end

    // hold the result side off once the stream is running, so the core backs up
    initial begin
        wait (sent == 600);
        @(negedge i_clk);
        hold = 1;
        repeat (HOLD_LEN) @(negedge i_clk);
        hold = 0;
    end

    task automatic apb_write(input logic [2:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        psel    = 1;
        pwrite  = 1;
        penable = 0;
        paddr   = {idx, 2'b00};
        pwdata  = val;
        @(negedge i_clk);
        penable = 1;
        @(negedge i_clk);
        psel    = 0;
        penable = 0;
        pwrite  = 0;
    endtask

    task automatic set_mounts(input int a0, input int a1, input int a2, input int a3,
                              input int lim);
        apb_write(REG_WHEEL0, 32'(a0));
        apb_write(REG_WHEEL1, 32'(a1));
        apb_write(REG_WHEEL2, 32'(a2));
        apb_write(REG_WHEEL3, 32'(a3));
        apb_write(REG_ROT, 32'(lim));
    endtask

    // offer one item, valid stays up across back-to-back items
    task automatic send_tick(input logic [15:0] hdg, input logic [15:0] tgt,
                             input logic [15:0] trav, input logic [15:0] spd,
                             input logic [31:0] period, input logic [31:0] now);
        int gap;
        s_tdata  = {now, period, spd, trav, tgt, hdg};
        s_tvalid = 1;
        #1;
        while (!s_tready) begin
            @(negedge i_clk);
            #1;
        end
        @(posedge i_clk);
        sent++;
        @(negedge i_clk);
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid = 0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic random_tick();
        int          h, t, sel;
        logic [31:0] period;
        sel = $urandom_range(0, 9);
        if (sel < 3) begin
            h = $urandom;
            t = $urandom;
        end else begin
            // error spread over all three gain bands
            h = $urandom_range(0, 3599) - 1800;
            t = h + $urandom_range(0, 2400) - 1200;
        end
        if ($urandom_range(0, 19) == 0) clock_ms = $urandom;
        else clock_ms = clock_ms + $urandom_range(0, 8);
        period = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 4);
        send_tick(16'(h), 16'(t), 16'($urandom),
                  ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40) - 20),
                  period, clock_ms);
    endtask

    task automatic settle();
        s_tvalid = 0;
        wait (pending == 0);
        repeat (150) @(negedge i_clk);
    endtask

    initial begin
        repeat (7) @(negedge i_clk);
        i_rst_n = 1;
        @(negedge i_clk);

        // directed: field extremes, gain band edges, heading wrap, error wrap
        send_tick(16'sd0, 16'sd0, 16'sd0, 16'sd5, 32'd0, 32'd0);
        send_tick(16'sd32767, 16'sd0, 16'sd900, 16'sd32767, 32'd0, 32'd1);
        send_tick(-16'sd32768, 16'sd32767, -16'sd32768, -16'sd32768, 32'd0, 32'd2);
        send_tick(16'sd1800, 16'sd0, 16'sd1800, 16'sd3, 32'd0, 32'd3);
        send_tick(-16'sd1800, 16'sd0, -16'sd1800, 16'sd3, 32'd0, 32'd4);
        send_tick(16'sd3599, 16'sd0, 16'sd3600, 16'sd3, 32'd0, 32'd5);
        send_tick(-16'sd3601, 16'sd0, 16'sd450, 16'sd3, 32'd0, 32'd6);
        send_tick(16'sd0, 16'sd399, 16'sd0, 16'sd3, 32'd0, 32'd7);
        send_tick(16'sd0, 16'sd400, 16'sd0, 16'sd3, 32'd0, 32'd8);
        send_tick(16'sd0, 16'sd999, 16'sd0, 16'sd3, 32'd0, 32'd9);
        send_tick(16'sd0, 16'sd1000, 16'sd0, 16'sd3, 32'd0, 32'd10);
        send_tick(16'sd0, -16'sd1000, 16'sd0, 16'sd3, 32'd0, 32'd11);
        send_tick(16'sd1799, 16'sd32767, 16'sd0, 16'sd3, 32'd0, 32'd12);
        send_tick(-16'sd1800, -16'sd32768, 16'sd0, 16'sd3, 32'd0, 32'd13);
        // huge period: no step, then wrap of the time stamp
        send_tick(16'sd0, 16'sd0, 16'sd0, 16'sd100, 32'hffff_ffff, 32'd14);
        send_tick(16'sd0, 16'sd0, 16'sd0, 16'sd100, 32'd5, 32'hffff_fffe);
        send_tick(16'sd0, 16'sd0, 16'sd0, -16'sd100, 32'd3, 32'd1);
        send_tick(16'sd0, 16'sd0, 16'sd0, -16'sd100, 32'd3, 32'd2);
        settle();

        // phase: default mounts with full correction range
        set_mounts(450, 1350, -1350, -450, 32767);
        apb_write(REG_SPARE, $urandom);
        clock_ms = 0;
        repeat (190) random_tick();
        settle();

        // phase: equal mounts on both pairs, zero denominators
        set_mounts(0, 1800, -1800, 0, 32767);
        send_tick(16'sd0, 16'sd500, 16'sd0, 16'sd7, 32'd0, clock_ms);
        repeat (150) random_tick();
        settle();

        // phase: angle extremes, no correction allowed, no idling
        calm = 1;
        set_mounts(-1800, 1800, -1800, 1800, 0);
        repeat (150) random_tick();
        settle();
        calm = 0;

        // phase: random mounts and clamp, the hold-off falls in here
        set_mounts($urandom_range(0, 3600) - 1800, $urandom_range(0, 3600) - 1800,
                   $urandom_range(0, 3600) - 1800, $urandom_range(0, 3600) - 1800,
                   $urandom_range(0, 32767));
        repeat (230) random_tick();
        settle();

        // phase: small clamp, mixed mounts
        set_mounts(900, -900, 1799, -1799, 1);
        repeat (210) random_tick();
        settle();

        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
